[design/sdofc_pkg.sv]
// ----------------------------------------------------------------------------
// sdofc_pkg
// Types, codes and constants shared by the SDO response frame checker.
// ----------------------------------------------------------------------------
package sdofc_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 10;
  localparam int LEN_W       = 11;
  localparam int CRC_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int JOINT_W     = 2;
  localparam int BIT_SEL_W   = 5;

  localparam int BITMAP_GROUPS = 5;
  localparam int GROUP_STRIDE  = 4;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [CFG_DATA_W-1:0] FRAME_HEADER_RST = 16'hAA55;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_HDR_HI  = 10'd0;
  localparam logic [POS_W-1:0] POS_HDR_LO  = 10'd1;
  localparam logic [POS_W-1:0] POS_SRC_ID  = 10'd2;
  localparam logic [POS_W-1:0] POS_DST_ID  = 10'd3;
  localparam logic [POS_W-1:0] POS_CTRL_HI = 10'd4;
  localparam logic [POS_W-1:0] POS_PROTO   = 10'd6;
  localparam logic [POS_W-1:0] POS_CMD     = 10'd8;
  localparam logic [POS_W-1:0] POS_IDX_HI  = 10'd9;
  localparam logic [POS_W-1:0] POS_IDX_LO  = 10'd10;
  localparam logic [POS_W-1:0] POS_SUBIDX  = 10'd11;
  localparam logic [POS_W-1:0] POS_DATA0   = 10'd14;
  localparam logic [POS_W-1:0] POS_DATA1   = 10'd15;
  localparam logic [POS_W-1:0] POS_DATA2   = 10'd16;
  localparam logic [POS_W-1:0] POS_DATA3   = 10'd17;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_PARAM_ERR = 2'd1,
    STATUS_DATA_ERR  = 2'd2,
    STATUS_NOT_FRAME = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEADER  = 3'd0,
    REG_NODE_ID       = 3'd1,
    REG_REMOTE_ID     = 3'd2,
    REG_PROTOCOL_CODE = 3'd3,
    REG_READ_OK_CODE  = 3'd4,
    REG_BITMAP_INDEX  = 3'd5,
    REG_JOINT_OFFSET  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        frame_header;
    logic [BYTE_W-1:0]  node_id;
    logic [BYTE_W-1:0]  remote_id;
    logic [BYTE_W-1:0]  protocol_code;
    logic [BYTE_W-1:0]  read_ok_code;
    logic [15:0]        bitmap_index;
    logic [JOINT_W-1:0] joint_offset;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] data_word;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic bitmap_ok(input logic [WORD_W-1:0] w,
                                     input logic [JOINT_W-1:0] joint);
    logic             ok;
    logic [BIT_SEL_W-1:0] sel;
    ok = 1'b1;
    for (int i = 0; i < BITMAP_GROUPS; i++) begin
      sel = BIT_SEL_W'(i * GROUP_STRIDE) + {{(BIT_SEL_W-JOINT_W){1'b0}}, joint};
      if (!w[sel]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[design/sdofc_if.sv]
// ----------------------------------------------------------------------------
// sdofc_if
// Valid/ready channels of the SDO response frame checker.
// ----------------------------------------------------------------------------
interface sdofc_in_if import sdofc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface sdofc_out_if import sdofc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, status, data_word, input ready);
  modport sink   (input valid, status, data_word, output ready);
endinterface

interface sdofc_cfg_if import sdofc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/sdofc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sdofc_cfg_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module sdofc_cfg_regs import sdofc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sdofc_cfg_if.sink   cfg_ch,
  output cfg_t        cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_FRAME_HEADER:  cfg_nxt.frame_header  = cfg_ch.data;
        REG_NODE_ID:       cfg_nxt.node_id       = cfg_ch.data[BYTE_W-1:0];
        REG_REMOTE_ID:     cfg_nxt.remote_id     = cfg_ch.data[BYTE_W-1:0];
        REG_PROTOCOL_CODE: cfg_nxt.protocol_code = cfg_ch.data[BYTE_W-1:0];
        REG_READ_OK_CODE:  cfg_nxt.read_ok_code  = cfg_ch.data[BYTE_W-1:0];
        REG_BITMAP_INDEX:  cfg_nxt.bitmap_index  = cfg_ch.data;
        REG_JOINT_OFFSET:  cfg_nxt.joint_offset  = cfg_ch.data[JOINT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_header  <= FRAME_HEADER_RST;
      cfg_r.node_id       <= '0;
      cfg_r.remote_id     <= '0;
      cfg_r.protocol_code <= '0;
      cfg_r.read_ok_code  <= '0;
      cfg_r.bitmap_index  <= '0;
      cfg_r.joint_offset  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/sdofc_in_reg.sv]
// ----------------------------------------------------------------------------
// sdofc_in_reg
// Input register: holds one received byte until the checker takes it.
// ----------------------------------------------------------------------------
module sdofc_in_reg import sdofc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sdofc_in_if.sink   in_ch,
  input  logic       adv_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || adv_i;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_o     = valid_r;
  assign item_o      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte   <= in_ch.data_byte;
      item_r.frame_start <= in_ch.frame_start;
    end
  end

endmodule

[design/sdofc_core.sv]
// ----------------------------------------------------------------------------
// sdofc_core
// Frame state, CRC-16/MODBUS and field checks, one byte per step.
// ----------------------------------------------------------------------------
module sdofc_core import sdofc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic              in_frame_r,  in_frame_nxt;
  logic [POS_W-1:0]  pos_r,       pos_nxt;
  logic [LEN_W-1:0]  len_r,       len_nxt;
  logic [CRC_W-1:0]  crc_r,       crc_nxt;
  logic [15:0]       last2_r,     last2_nxt;
  logic [BYTE_W-1:0] hdr_r,       hdr_nxt;
  logic              proto_bad_r, proto_bad_nxt;
  logic [BYTE_W-1:0] cmd_r,       cmd_nxt;
  logic [15:0]       idx_r,       idx_nxt;
  logic [BYTE_W-1:0] sub_r,       sub_nxt;
  logic [WORD_W-1:0] word_r,      word_nxt;

  logic              start;
  logic [POS_W-1:0]  p;
  logic [CRC_W-1:0]  crc_b;
  logic [15:0]       last2_b;
  logic [BYTE_W-1:0] b;

  assign start = item_i.frame_start;
  assign b     = item_i.data_byte;
  assign p       = start ? POS_HDR_HI : pos_r;
  assign crc_b   = start ? CRC_INIT : crc_r;
  assign last2_b = start ? 16'h0000 : last2_r;

  always_comb begin
    in_frame_nxt  = in_frame_r;
    pos_nxt       = pos_r;
    len_nxt       = start ? '0 : len_r;
    crc_nxt       = crc_b;
    last2_nxt     = last2_b;
    hdr_nxt       = start ? '0 : hdr_r;
    proto_bad_nxt = start ? 1'b0 : proto_bad_r;
    cmd_nxt       = start ? '0 : cmd_r;
    idx_nxt       = start ? '0 : idx_r;
    sub_nxt       = start ? '0 : sub_r;
    word_nxt      = start ? '0 : word_r;
    res_valid_o   = 1'b0;
    res_o.status    = STATUS_OK;
    res_o.data_word = '0;

    if (start || in_frame_r) begin
      in_frame_nxt = 1'b1;
      // CRC trails by two bytes so the trailing checksum is left out
      if (p >= POS_SRC_ID) begin
        crc_nxt = crc_byte(crc_b, last2_b[15:8]);
      end
      last2_nxt = {last2_b[7:0], b};

      case (p)
        POS_HDR_HI:  hdr_nxt = b;
        POS_HDR_LO: begin
          if ({hdr_nxt, b} != cfg_i.frame_header) begin
            res_valid_o  = 1'b1;
            res_o.status = STATUS_NOT_FRAME;
          end
        end
        POS_SRC_ID:  hdr_nxt = b;
        POS_DST_ID: begin
          if (b != cfg_i.node_id || hdr_nxt != cfg_i.remote_id) begin
            res_valid_o  = 1'b1;
            res_o.status = STATUS_PARAM_ERR;
          end
        end
        POS_CTRL_HI: len_nxt = ({5'b0, b[7:2]} + 11'd1) << 4;
        POS_PROTO:   proto_bad_nxt = (b != cfg_i.protocol_code);
        POS_CMD:     cmd_nxt = b;
        POS_IDX_HI:  idx_nxt = {b, 8'h00};
        POS_IDX_LO:  idx_nxt = {idx_nxt[15:8], b};
        POS_SUBIDX:  sub_nxt = b;
        POS_DATA0:   word_nxt[7:0]   = b;
        POS_DATA1:   word_nxt[15:8]  = b;
        POS_DATA2:   word_nxt[23:16] = b;
        POS_DATA3:   word_nxt[31:24] = b;
        default:     ;
      endcase

      if (!res_valid_o && ({1'b0, p} + 11'd1) == len_nxt) begin
        res_valid_o     = 1'b1;
        res_o.data_word = word_nxt;
        if (crc_nxt != last2_nxt || proto_bad_nxt) begin
          res_o.status = STATUS_PARAM_ERR;
        end else if (cmd_nxt != cfg_i.read_ok_code) begin
          res_o.status = STATUS_DATA_ERR;
        end else if (idx_nxt != cfg_i.bitmap_index || sub_nxt != '0) begin
          res_o.status = STATUS_DATA_ERR;
        end else if (!bitmap_ok(word_nxt, cfg_i.joint_offset)) begin
          res_o.status = STATUS_DATA_ERR;
        end else begin
          res_o.status = STATUS_OK;
        end
      end

      if (res_valid_o) begin
        in_frame_nxt = 1'b0;
      end else begin
        pos_nxt = p + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      len_r      <= '0;
    end else if (step_i) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i) begin
      crc_r       <= crc_nxt;
      last2_r     <= last2_nxt;
      hdr_r       <= hdr_nxt;
      proto_bad_r <= proto_bad_nxt;
      cmd_r       <= cmd_nxt;
      idx_r       <= idx_nxt;
      sub_r       <= sub_nxt;
      word_r      <= word_nxt;
    end
  end

`ifndef SYNTH
  a_close_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_valid_o |=> !in_frame_r)
    else $error("frame still open after its result");

  a_early_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_o && (res_o.status == STATUS_NOT_FRAME) |-> res_o.data_word == '0)
    else $error("header failure carries a data word");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r && (len_r != '0) |-> ({1'b0, pos_r} < len_r))
    else $error("byte position past frame length");
`endif

endmodule

[design/sdofc_out_reg.sv]
// ----------------------------------------------------------------------------
// sdofc_out_reg
// Result register: holds a status item until the sink takes it.
// ----------------------------------------------------------------------------
module sdofc_out_reg import sdofc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid_i,
  input  result_t     res_i,
  output logic        adv_o,
  sdofc_out_if.source out_ch
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign adv_o            = !valid_r || out_ch.ready;
  assign out_ch.valid     = valid_r;
  assign out_ch.status    = res_r.status;
  assign out_ch.data_word = res_r.data_word;

  assign valid_nxt = adv_o ? res_valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && res_valid_i) begin
      res_r <= res_i;
    end
  end

endmodule

[design/sdo_response_frame_checker_top.sv]
// ----------------------------------------------------------------------------
// sdo_response_frame_checker_top: one byte item per cycle, back to back, unless a held status item stalls it.
// Status is registered in the result register after the frame's last or failing byte leaves the input register.
// A held status item stalls input once the input register is full as well.
// Synchronous active-low reset closes any frame and empties both registers.
// ----------------------------------------------------------------------------
module sdo_response_frame_checker_top import sdofc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sdofc_in_if.sink    in_ch,
  sdofc_out_if.source out_ch,
  sdofc_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    adv;
  logic    step;
  logic    res_valid;
  result_t res;

  assign step = item_valid && adv;

  sdofc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  sdofc_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .adv_i   (adv),
    .valid_o (item_valid),
    .item_o  (item)
  );

  sdofc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .item_i      (item),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdofc_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (step && res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_ch      (out_ch)
  );

endmodule
